### hw/rtl/uartrx_pkg.sv
package uartrx_pkg;

  // Input beat kinds, carried on s_axis_tuser.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LINE  = 2'd2;

  // Register byte offsets.
  localparam logic [7:0] OFF_MODE = 8'h00;
  localparam logic [7:0] OFF_STA  = 8'h10;
  localparam logic [7:0] OFF_TX   = 8'h20;
  localparam logic [7:0] OFF_RX   = 8'h30;
  localparam logic [7:0] OFF_BAUD = 8'h40;

  // Mode and status bit positions.
  localparam int M_ON    = 15;
  localparam int S_RXDA  = 0;
  localparam int S_OERR  = 1;
  localparam int S_TXBF  = 9;
  localparam int S_TXEN  = 10;
  localparam int S_RXEN  = 12;

  localparam logic [31:0] STATUS_RESET = 32'h0000_0110;
  localparam logic [31:0] STATUS_WMASK = 32'hFFFF_FFF2;

endpackage

### hw/rtl/uartrx_ram.sv
module uartrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/uart_registers_rx_fifo.sv
// An accepted input beat's result beat is registered and is valid in the cycle after it is accepted.
// Throughput: one beat per cycle; s_axis_tready is high whenever the result
// register is empty or being drained in the same cycle.
// The receive FIFO is a circular buffer in a RAM with a registered read port.
// Reset (rst, synchronous): mode and baud cleared, status = 0x110, FIFO empty,
// no result pending. FIFO contents are not cleared and need no sweep.
module uart_registers_rx_fifo
  import uartrx_pkg::*;
#(
  parameter int RX_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address[7:0], write_data[39:8], line_byte[47:40]
  input  logic [47:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[31:0], tx_valid[32], tx_byte[40:33], rx_irq[41], tx_irq[42],
  // fault_irq[43], rx_space[47:44]
  output logic [47:0] m_axis_tdata
);

  localparam int PTR_W  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int FILL_W = $clog2(RX_DEPTH + 1);
  localparam int SP_W   = (FILL_W > 4) ? FILL_W : 4;
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RX_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RX_DEPTH);

  logic [1:0]  command;
  logic [7:0]  address;
  logic [31:0] write_data;
  logic [7:0]  line_byte;
  logic        accept;

  assign command    = s_axis_tuser;
  assign address    = s_axis_tdata[7:0];
  assign write_data = s_axis_tdata[39:8];
  assign line_byte  = s_axis_tdata[47:40];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Architectural state.
  logic [31:0]       mode_word, mode_word_next;
  logic [31:0]       status_word, status_word_next;
  logic [15:0]       baud_divisor, baud_divisor_next;
  logic [FILL_W-1:0] rx_fill, rx_fill_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;

  // Result register.
  logic [31:0] out_read, out_read_next;
  logic        out_pop, out_pop_next;
  logic        out_txv, out_txv_next;
  logic [7:0]  out_txb, out_txb_next;
  logic        out_rx_irq, out_tx_irq, out_fault_irq;
  logic [3:0]  out_space;

  logic        fifo_we;
  logic        on_now;
  logic        on_next;
  logic [SP_W-1:0] space_wide;
  logic [7:0]  ram_q;

  assign on_now = mode_word[M_ON];

  always_comb begin
    mode_word_next    = mode_word;
    status_word_next  = status_word;
    baud_divisor_next = baud_divisor;
    rx_fill_next      = rx_fill;
    rd_ptr_next       = rd_ptr;
    wr_ptr_next       = wr_ptr;
    out_read_next     = '0;
    out_pop_next      = 1'b0;
    out_txv_next      = 1'b0;
    out_txb_next      = '0;
    fifo_we           = 1'b0;
    if (accept) begin
      case (command)
        CMD_READ: begin
          case (address)
            OFF_MODE: out_read_next = mode_word;
            OFF_STA:  out_read_next = status_word;
            OFF_BAUD: out_read_next = {16'h0000, baud_divisor};
            OFF_RX: begin
              if (rx_fill != '0) begin
                // The byte comes out of the registered RAM read port together with the result beat.
                out_pop_next = 1'b1;
                rx_fill_next = rx_fill - 1'b1;
                rd_ptr_next  = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
                if (rx_fill == FILL_W'(1)) begin
                  status_word_next[S_RXDA] = 1'b0;
                end
              end
            end
            default: out_read_next = '0;
          endcase
        end
        CMD_WRITE: begin
          case (address)
            OFF_MODE: begin
              mode_word_next = write_data;
              if (!write_data[M_ON]) begin
                rx_fill_next             = '0;
                rd_ptr_next              = '0;
                wr_ptr_next              = '0;
                status_word_next[S_RXDA] = 1'b0;
                status_word_next[S_OERR] = 1'b0;
              end
            end
            OFF_STA: begin
              // Clearing a pending overrun also throws away the FIFO contents.
              if (status_word[S_OERR] && !write_data[S_OERR]) begin
                rx_fill_next             = '0;
                rd_ptr_next              = '0;
                wr_ptr_next              = '0;
                status_word_next[S_RXDA] = 1'b0;
              end
              status_word_next = (status_word_next & ~STATUS_WMASK)
                               | (write_data & STATUS_WMASK);
            end
            OFF_TX: begin
              if (on_now && status_word[S_TXEN]) begin
                out_txv_next = 1'b1;
                out_txb_next = write_data[7:0];
              end
            end
            OFF_BAUD: baud_divisor_next = write_data[15:0];
            default: baud_divisor_next = baud_divisor;
          endcase
        end
        CMD_LINE: begin
          if (on_now && status_word[S_RXEN]) begin
            if (rx_fill >= FILL_MAX) begin
              status_word_next[S_OERR] = 1'b1;
            end else begin
              fifo_we      = 1'b1;
              rx_fill_next = rx_fill + 1'b1;
              wr_ptr_next  = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
            end
            status_word_next[S_RXDA] = 1'b1;
          end
        end
        default: out_read_next = '0;
      endcase
    end
  end

  assign on_next    = mode_word_next[M_ON];
  assign space_wide = SP_W'(RX_DEPTH) - SP_W'(rx_fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_word     <= '0;
      status_word   <= STATUS_RESET;
      baud_divisor  <= '0;
      rx_fill       <= '0;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      mode_word    <= mode_word_next;
      status_word  <= status_word_next;
      baud_divisor <= baud_divisor_next;
      rx_fill      <= rx_fill_next;
      rd_ptr       <= rd_ptr_next;
      wr_ptr       <= wr_ptr_next;
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read      <= out_read_next;
      out_pop       <= out_pop_next;
      out_txv       <= out_txv_next;
      out_txb       <= out_txb_next;
      out_rx_irq    <= on_next && status_word_next[S_RXDA];
      out_tx_irq    <= on_next && status_word_next[S_TXEN] && !status_word_next[S_TXBF];
      out_fault_irq <= on_next && status_word_next[S_OERR];
      out_space     <= (on_next && status_word_next[S_RXEN]) ? space_wide[3:0] : 4'd0;
    end
  end

  uartrx_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wr_ptr),
    .wdata (line_byte),
    .re    (out_pop_next),
    .raddr (rd_ptr),
    .rdata (ram_q)
  );

  assign m_axis_tdata = {out_space, out_fault_irq, out_tx_irq, out_rx_irq, out_txb, out_txv,
                         (out_pop ? {24'h000000, ram_q} : out_read)};

endmodule

### hw/rtl/uartrx_chk.sv
module uartrx_chk
  import uartrx_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic s_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;

  // Every accepted beat produces its result beat in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_beat |=> m_axis_tvalid)
    else $error("result beat missing after accepted input");

  // Only bus reads return data.
  a_read_only_on_read: assert property (@(posedge clk) disable iff (rst)
    s_beat && s_axis_tuser != CMD_READ |=> m_axis_tdata[31:0] == 32'h0)
    else $error("nonzero read data for a non-read beat");

  a_tx_byte_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[40:33] == 8'h00)
    else $error("tx byte nonzero without tx valid");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind uart_registers_rx_fifo uartrx_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_uart_registers_rx_fifo.sv
module tb_uart_registers_rx_fifo;
  import uartrx_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RX_DEPTH       = 8;
  localparam int LONG_HOLD      = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  // The fourth command code has no meaning to the block and must change nothing.
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Same bit order as m_axis_tdata, from the top bit down.
  typedef struct packed {
    logic [3:0]  rx_space;
    logic        fault_irq;
    logic        tx_irq;
    logic        rx_irq;
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic [31:0] read_data;
  } uart_response_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // address[7:0], write_data[39:8], line_byte[47:40]
  logic [1:0]  s_axis_tuser;   // command[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // read_data[31:0], tx_valid[32], tx_byte[40:33],
                               // rx_irq[41], tx_irq[42], fault_irq[43], rx_space[47:44]

  // Shadow copy of the register file and the receive FIFO.
  logic [31:0] mode_reg;
  logic [31:0] status_reg;
  logic [15:0] baud_reg;
  logic [7:0]  rx_bytes[$];

  uart_response_t pending_responses[$];
  uart_response_t got_resp;
  uart_response_t want_resp;

  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  bit hold_request = 1'b0;
  int err_cnt = 0;
  int n_reads = 0, n_writes = 0, n_lines = 0, n_unused = 0;
  int n_tx_sent = 0, n_dropped = 0, n_popped = 0, n_held = 0;

  uart_registers_rx_fifo #(.RX_DEPTH(RX_DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic uart_response_t uart_response(input logic [1:0] cmd,
                                                   input logic [7:0] addr,
                                                   input logic [31:0] wd,
                                                   input logic [7:0] lb);
    uart_response_t r;
    logic on;
    r = '0;
    case (cmd)
      CMD_READ: begin
        if (addr == OFF_MODE) r.read_data = mode_reg;
        else if (addr == OFF_STA) r.read_data = status_reg;
        else if (addr == OFF_BAUD) r.read_data = {16'h0, baud_reg};
        else if (addr == OFF_RX && rx_bytes.size() != 0) begin
          r.read_data = {24'h0, rx_bytes.pop_front()};
          n_popped++;
          if (rx_bytes.size() == 0) status_reg[S_RXDA] = 1'b0;
        end
      end
      CMD_WRITE: begin
        if (addr == OFF_MODE) begin
          mode_reg = wd;
          if (!wd[M_ON]) begin
            rx_bytes.delete();
            status_reg[S_RXDA] = 1'b0;
            status_reg[S_OERR] = 1'b0;
          end
        end else if (addr == OFF_STA) begin
          // Clearing a pending overrun throws away whatever is buffered.
          if (status_reg[S_OERR] && !wd[S_OERR]) begin
            rx_bytes.delete();
            status_reg[S_RXDA] = 1'b0;
          end
          status_reg = (status_reg & ~STATUS_WMASK) | (wd & STATUS_WMASK);
        end else if (addr == OFF_TX) begin
          if (mode_reg[M_ON] && status_reg[S_TXEN]) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = wd[7:0];
            n_tx_sent++;
          end
        end else if (addr == OFF_BAUD) begin
          baud_reg = wd[15:0];
        end
      end
      CMD_LINE: begin
        if (mode_reg[M_ON] && status_reg[S_RXEN]) begin
          if (rx_bytes.size() >= RX_DEPTH) begin
            status_reg[S_OERR] = 1'b1;
            n_dropped++;
          end else begin
            rx_bytes.push_back(lb);
          end
          status_reg[S_RXDA] = 1'b1;
        end
      end
      default: ;
    endcase
    on          = mode_reg[M_ON];
    r.rx_irq    = on & status_reg[S_RXDA];
    r.tx_irq    = on & status_reg[S_TXEN] & ~status_reg[S_TXBF];
    r.fault_irq = on & status_reg[S_OERR];
    r.rx_space  = (on && status_reg[S_RXEN]) ? 4'(RX_DEPTH - rx_bytes.size()) : 4'd0;
    return r;
  endfunction

  // Input side: every accepted beat is run through the shadow model.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      case (s_axis_tuser)
        CMD_READ:  n_reads++;
        CMD_WRITE: n_writes++;
        CMD_LINE:  n_lines++;
        default:   n_unused++;
      endcase
      pending_responses.push_back(uart_response(s_axis_tuser, s_axis_tdata[7:0],
                                                s_axis_tdata[39:8], s_axis_tdata[47:40]));
    end
  end

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_resp = m_axis_tdata;
      if (pending_responses.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got %h",
                 $time, m_axis_tdata);
        err_cnt++;
      end else begin
        want_resp = pending_responses.pop_front();
        check_field("read_data", want_resp.read_data, got_resp.read_data);
        check_field("tx_valid", 32'(want_resp.tx_valid), 32'(got_resp.tx_valid));
        check_field("tx_byte", 32'(want_resp.tx_byte), 32'(got_resp.tx_byte));
        check_field("rx_irq", 32'(want_resp.rx_irq), 32'(got_resp.rx_irq));
        check_field("tx_irq", 32'(want_resp.tx_irq), 32'(got_resp.tx_irq));
        check_field("fault_irq", 32'(want_resp.fault_irq), 32'(got_resp.fault_irq));
        check_field("rx_space", 32'(want_resp.rx_space), 32'(got_resp.rx_space));
      end
    end
  end

  // Receiver: short random stalls, plus one long hold on request.
  initial begin : result_sink
    int held;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(negedge clk);
          held++;
        end
        n_held += held;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Entered and left at a falling edge.
  task automatic send_beat(input logic [1:0] cmd, input logic [7:0] addr,
                           input logic [31:0] wd, input logic [7:0] lb);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {lb, wd, addr};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_beat(CMD_READ, OFF_MODE, 32'h0, 8'h0);
    send_beat(CMD_READ, OFF_STA, 32'hFFFF_FFFF, 8'hFF);
    send_beat(CMD_READ, OFF_RX, 32'h0, 8'h0);
    send_beat(CMD_READ, 8'hFF, 32'h0, 8'h0);
    send_beat(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    send_beat(CMD_LINE, OFF_MODE, 32'h0, 8'h5A);
  endtask

  task automatic test_register_access();
    send_beat(CMD_WRITE, OFF_BAUD, 32'hFFFF_FFFF, 8'h0);
    send_beat(CMD_READ, OFF_BAUD, 32'h0, 8'h0);
    send_beat(CMD_WRITE, OFF_TX, 32'h0000_003C, 8'h0);
    send_beat(CMD_WRITE, OFF_MODE, 32'hFFFF_FFFF, 8'h0);
    // All ones sets overrun and buffer-full; the next write clears overrun again.
    send_beat(CMD_WRITE, OFF_STA, 32'hFFFF_FFFF, 8'h0);
    send_beat(CMD_WRITE, OFF_STA, 32'h0000_1400, 8'h0);
    send_beat(CMD_WRITE, OFF_TX, 32'hFFFF_FFA5, 8'h0);
    send_beat(CMD_WRITE, OFF_RX, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_fifo_overrun();
    send_beat(CMD_LINE, OFF_MODE, 32'h0, 8'h00);
    send_beat(CMD_LINE, OFF_MODE, 32'h0, 8'hFF);
    repeat (RX_DEPTH - 1) send_beat(CMD_LINE, 8'($urandom), $urandom, 8'($urandom));
    send_beat(CMD_READ, OFF_RX, 32'h0, 8'h0);
    send_beat(CMD_WRITE, OFF_STA, 32'h0000_1400, 8'h0);
    send_beat(CMD_LINE, OFF_MODE, 32'h0, 8'h81);
    send_beat(CMD_WRITE, OFF_MODE, 32'h0, 8'h0);
  endtask

  task automatic test_backpressure();
    send_beat(CMD_WRITE, OFF_MODE, 32'h0000_8000, 8'h0);
    send_beat(CMD_WRITE, OFF_STA, 32'h0000_1400, 8'h0);
    hold_request = 1'b1;
    repeat (12) send_beat(CMD_LINE, 8'($urandom), $urandom, 8'($urandom));
    repeat (12) send_beat(CMD_READ, OFF_RX, $urandom, 8'($urandom));
  endtask

  task automatic test_random(input int n_beats);
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [31:0] wd;
    int lean, roll, pick, line_pct, read_pct;
    lean = 0;
    for (int i = 0; i < n_beats; i++) begin
      // Alternate between filling, draining and mixed stretches.
      if (i % 40 == 0) lean = $urandom_range(0, 2);
      line_pct = (lean == 1) ? 60 : (lean == 2) ? 20 : 40;
      read_pct = (lean == 1) ? 20 : (lean == 2) ? 60 : 40;
      roll = $urandom_range(0, 99);
      if (roll < 2) cmd = CMD_NONE;
      else if (roll < 2 + line_pct) cmd = CMD_LINE;
      else if (roll < 2 + line_pct + read_pct) cmd = CMD_READ;
      else cmd = CMD_WRITE;
      wd   = $urandom;
      pick = $urandom_range(0, 9);
      if (cmd == CMD_READ) begin
        case (pick)
          5:       addr = OFF_MODE;
          6:       addr = OFF_STA;
          7:       addr = OFF_BAUD;
          8:       addr = OFF_TX;
          9:       addr = 8'($urandom_range(0, 255));
          default: addr = OFF_RX;
        endcase
      end else if (cmd == CMD_WRITE) begin
        case (pick)
          0, 1: begin
            addr = OFF_MODE;
            if ($urandom_range(0, 9) != 0) wd[M_ON] = 1'b1;
          end
          2, 3, 4: begin
            addr = OFF_STA;
            if ($urandom_range(0, 9) != 0) begin
              wd[S_RXEN] = 1'b1;
              wd[S_TXEN] = 1'b1;
            end
            wd[S_OERR] = ($urandom_range(0, 3) != 0);
          end
          5, 6:    addr = OFF_TX;
          7:       addr = OFF_BAUD;
          8:       addr = OFF_RX;
          default: addr = 8'($urandom_range(0, 255));
        endcase
      end else begin
        addr = 8'($urandom_range(0, 255));
      end
      send_beat(cmd, addr, wd, 8'($urandom));
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_READ;
    mode_reg      = '0;
    status_reg    = STATUS_RESET;
    baud_reg      = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_register_access();
    test_fifo_overrun();
    test_backpressure();
    test_random(1550);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    test_random(250);

    s_axis_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d reads, %0d writes, %0d line bytes, %0d unused commands; %0d tx bytes.",
             n_reads, n_writes, n_lines, n_unused, n_tx_sent);
    $display("Receive FIFO: %0d bytes popped, %0d dropped on overrun, %0d-cycle output hold.",
             n_popped, n_dropped, n_held);
    if (err_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
